// ===== src/u8d_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 stream decoder.
// Used by u8d_decode, u8d_emit, utf8_stream_decoder and the bench; depends on nothing.
package u8d_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned REP_W    = 3;
  localparam int unsigned MAX_RUN  = 4;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] MIN_TWO     = 21'h000080;
  localparam logic [CP_W-1:0] MIN_THREE   = 21'h000800;
  localparam logic [CP_W-1:0] MIN_FOUR    = 21'h010000;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;

  // Continuations a lead asks for
  localparam logic [1:0] EXP_NONE  = 2'd0;
  localparam logic [1:0] EXP_ONE   = 2'd1;
  localparam logic [1:0] EXP_TWO   = 2'd2;
  localparam logic [1:0] EXP_THREE = 2'd3;

  // Results one byte causes: rep_count replacements, then an optional good code point
  typedef struct packed {
    logic [REP_W-1:0] rep_count;
    logic             has_good;
    logic [CP_W-1:0]  cp;
  } run_t;

endpackage

// ===== src/u8d_decode.sv =====
`timescale 1ns / 1ps
// Byte classifier and sequence state for the UTF-8 stream decoder.
// Turns one accepted word into a run descriptor; depends on u8d_pkg.
module u8d_decode (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  input  logic                    take,
  input  logic [7:0]              byte_value,
  input  logic                    end_of_text,
  output u8d_pkg::run_t           run
);

  logic [1:0]                 exp_r, exp_nxt;
  logic [1:0]                 taken_r, taken_nxt;
  logic [u8d_pkg::CP_W-1:0]   pv_r, pv_nxt;
  logic                       allow_r;

  logic                       pending, is_cont;
  logic                       f_ascii, f_lead2, f_lead3, f_lead4, f_lead, f_bad;
  logic [1:0]                 taken_inc;
  logic [u8d_pkg::CP_W-1:0]   pv_shift, minimum;
  logic                       seq_ok;
  logic [u8d_pkg::REP_W-1:0]  pre, reps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_r <= 1'b0;
      exp_r   <= u8d_pkg::EXP_NONE;
      taken_r <= 2'd0;
      pv_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        allow_r <= cfg_wr_data;
      end
      if (take) begin
        exp_r   <= exp_nxt;
        taken_r <= taken_nxt;
        pv_r    <= pv_nxt;
      end
    end
  end

  always_comb begin
    pending   = (exp_r != u8d_pkg::EXP_NONE);
    is_cont   = (byte_value[7:6] == 2'b10);
    f_ascii   = !byte_value[7];
    f_lead2   = (byte_value[7:5] == 3'b110);
    f_lead3   = (byte_value[7:4] == 4'b1110);
    f_lead4   = (byte_value[7:3] == 5'b11110);
    f_lead    = f_lead2 || f_lead3 || f_lead4;
    f_bad     = !f_ascii && !f_lead;
    taken_inc = 2'(taken_r + 2'd1);
    // payload shifted up, upper bits fall off the 21-bit field
    pv_shift  = {pv_r[u8d_pkg::CP_W-7:0], byte_value[5:0]};

    case (exp_r)
      u8d_pkg::EXP_ONE: minimum = u8d_pkg::MIN_TWO;
      u8d_pkg::EXP_TWO: minimum = u8d_pkg::MIN_THREE;
      default:          minimum = u8d_pkg::MIN_FOUR;
    endcase
    seq_ok = (pv_shift >= minimum) && (pv_shift <= u8d_pkg::CP_MAX) &&
             (allow_r || pv_shift < u8d_pkg::SURR_LO || pv_shift > u8d_pkg::SURR_HI);

    exp_nxt   = u8d_pkg::EXP_NONE;
    taken_nxt = 2'd0;
    pv_nxt    = '0;
    reps      = '0;
    run.has_good = 1'b0;
    run.cp       = {{(u8d_pkg::CP_W-8){1'b0}}, byte_value};
    pre          = pending ? 3'({1'b0, taken_r} + 3'd1) : 3'd0;

    if (pending && is_cont) begin
      if (taken_inc >= exp_r) begin
        if (seq_ok) begin
          run.has_good = 1'b1;
          run.cp       = pv_shift;
        end else begin
          reps = 3'({1'b0, exp_r} + 3'd1);
        end
      end else if (end_of_text) begin
        reps = 3'({1'b0, taken_inc} + 3'd1);
      end else begin
        exp_nxt   = exp_r;
        taken_nxt = taken_inc;
        pv_nxt    = pv_shift;
      end
    end else begin
      // broken sequence (if any) flushes first, then the byte decodes afresh
      reps         = 3'(pre + {2'b00, f_bad} + {2'b00, f_lead && end_of_text});
      run.has_good = f_ascii;
      if (f_lead && !end_of_text) begin
        if (f_lead2) begin
          exp_nxt = u8d_pkg::EXP_ONE;
          pv_nxt  = {{(u8d_pkg::CP_W-5){1'b0}}, byte_value[4:0]};
        end else if (f_lead3) begin
          exp_nxt = u8d_pkg::EXP_TWO;
          pv_nxt  = {{(u8d_pkg::CP_W-4){1'b0}}, byte_value[3:0]};
        end else begin
          exp_nxt = u8d_pkg::EXP_THREE;
          pv_nxt  = {{(u8d_pkg::CP_W-3){1'b0}}, byte_value[2:0]};
        end
      end
    end

    // a run never holds more than four results
    if (reps > 3'(u8d_pkg::MAX_RUN)) begin
      run.rep_count = 3'(u8d_pkg::MAX_RUN);
    end else begin
      run.rep_count = reps;
    end
  end

endmodule

// ===== src/u8d_emit.sv =====
`timescale 1ns / 1ps
// Result register for the UTF-8 stream decoder: holds one run descriptor
// and plays it out one word per cycle while out_stall is low. Depends on u8d_pkg.
module u8d_emit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  u8d_pkg::run_t           run,
  output logic                    busy,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [20:0]             out_scalar,
  output logic                    out_is_error,
  output logic                    out_run_last
);

  logic                       valid_r, valid_nxt;
  logic [u8d_pkg::REP_W-1:0]  rep_r, rep_nxt;
  logic                       good_r, good_nxt;
  logic [u8d_pkg::CP_W-1:0]   cp_r;
  logic                       pop, last;

  always_comb begin
    last = (rep_r == 3'd0) || (rep_r == 3'd1 && !good_r);
    pop  = valid_r && !out_stall;
    // stay busy unless the final word of the run leaves this cycle
    busy = valid_r && !(pop && last);

    valid_nxt = valid_r;
    rep_nxt   = rep_r;
    good_nxt  = good_r;
    if (pop) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else if (rep_r != 3'd0) begin
        rep_nxt = 3'(rep_r - 3'd1);
      end
    end
    if (load) begin
      valid_nxt = 1'b1;
      rep_nxt   = run.rep_count;
      good_nxt  = run.has_good;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rep_r   <= '0;
      good_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rep_r   <= rep_nxt;
      good_r  <= good_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r <= run.cp;
    end
  end

  assign out_valid    = valid_r;
  assign out_is_error = (rep_r != 3'd0);
  assign out_scalar   = (rep_r != 3'd0) ? u8d_pkg::REPLACEMENT : cp_r;
  assign out_run_last = last;

endmodule

// ===== src/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the UTF-8 stream decoder; instantiates u8d_decode and u8d_emit,
// uses u8d_pkg.
//
// Decodes one byte per accepted word into zero to four 21-bit code points.
// Each byte is classified and folded into the pending sequence in the cycle it
// is accepted; its results sit in a single result register and leave one word
// per cycle while out_stall is low, so bytes that yield one result (or none)
// stream at one per cycle. A byte that yields more than one result holds the input
// stalled while the result register plays out its replacements (U+FFFD, is_error set).
// Bad leads, rejected sequences (overlong, above 10FFFF, surrogates unless
// cfg_wr_data=1 was written), broken sequences and a sequence left open at
// end_of_text all produce replacements; run_last marks the final result of a byte.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_scalar,
  output logic        out_is_error,
  output logic        out_run_last
);

  u8d_pkg::run_t run;
  logic          take, busy, load;

  assign in_stall = busy;
  assign take     = in_valid && !busy;
  // drop runs that produce nothing
  assign load     = take && (run.has_good || run.rep_count != 3'd0);

  u8d_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .byte_value  (in_byte_value),
    .end_of_text (in_end_of_text),
    .run         (run)
  );

  u8d_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .run          (run),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scalar   (out_scalar),
    .out_is_error (out_is_error),
    .out_run_last (out_run_last)
  );

endmodule

// ===== tb/utf8_cp_checker.sv =====
`timescale 1ns / 1ps
// Checker for utf8_stream_decoder: watches the config port and both word channels,
// predicts the code points each accepted byte yields and compares them in order.
// Depends on u8d_pkg for widths and code point limits.
module utf8_cp_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [7:0]               in_byte_value,
  input  logic                     in_end_of_text,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [u8d_pkg::CP_W-1:0] out_scalar,
  input  logic                     out_is_error,
  input  logic                     out_run_last,
  output int                       fail_count,
  output int                       words_pending
);

  typedef struct packed {
    logic [u8d_pkg::CP_W-1:0] cp;
    logic                     err;
    logic                     last;
  } cp_word_t;

  cp_word_t                 cp_expect_q[$];
  cp_word_t                 run_buf[u8d_pkg::MAX_RUN];
  int                       run_len;
  logic                     surr_ok;
  logic [1:0]               seq_need;
  logic [1:0]               seq_got;
  logic [u8d_pkg::CP_W-1:0] seq_bits;

  function automatic void add_word(input logic [u8d_pkg::CP_W-1:0] cp, input logic err);
    if (run_len < u8d_pkg::MAX_RUN) begin
      run_buf[run_len] = {cp, err, 1'b0};
      run_len++;
    end
  endfunction

  function automatic void add_replacements(input int count);
    for (int k = 0; k < count; k++) add_word(u8d_pkg::REPLACEMENT, 1'b1);
  endfunction

  function automatic void drop_sequence();
    seq_need = u8d_pkg::EXP_NONE;
    seq_got  = 2'd0;
    seq_bits = '0;
  endfunction

  function automatic void start_fresh(input logic [7:0] b);
    if (b < 8'h80) begin
      add_word({13'd0, b}, 1'b0);
    end else if ((b & 8'hE0) == 8'hC0) begin
      seq_need = u8d_pkg::EXP_ONE;
      seq_got  = 2'd0;
      seq_bits = {16'd0, b[4:0]};
    end else if ((b & 8'hF0) == 8'hE0) begin
      seq_need = u8d_pkg::EXP_TWO;
      seq_got  = 2'd0;
      seq_bits = {17'd0, b[3:0]};
    end else if ((b & 8'hF8) == 8'hF0) begin
      seq_need = u8d_pkg::EXP_THREE;
      seq_got  = 2'd0;
      seq_bits = {18'd0, b[2:0]};
    end else begin
      add_word(u8d_pkg::REPLACEMENT, 1'b1);
    end
  endfunction

  function automatic logic seq_valid(input logic [u8d_pkg::CP_W-1:0] cp,
                                     input logic [1:0] need);
    logic [u8d_pkg::CP_W-1:0] floor_cp;
    case (need)
      u8d_pkg::EXP_ONE: floor_cp = u8d_pkg::MIN_TWO;
      u8d_pkg::EXP_TWO: floor_cp = u8d_pkg::MIN_THREE;
      default:          floor_cp = u8d_pkg::MIN_FOUR;
    endcase
    if (cp < floor_cp || cp > u8d_pkg::CP_MAX) return 1'b0;
    if (!surr_ok && cp >= u8d_pkg::SURR_LO && cp <= u8d_pkg::SURR_HI) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    run_len = 0;
    if (seq_need != u8d_pkg::EXP_NONE) begin
      if (b[7:6] == 2'b10) begin
        seq_bits = {seq_bits[u8d_pkg::CP_W-7:0], b[5:0]};
        seq_got  = seq_got + 2'd1;
        if (seq_got >= seq_need) begin
          if (seq_valid(seq_bits, seq_need)) add_word(seq_bits, 1'b0);
          else add_replacements(1 + seq_need);
          drop_sequence();
        end
      end else begin
        // broken sequence: replace what was taken, then decode this byte anew
        add_replacements(1 + seq_got);
        drop_sequence();
        start_fresh(b);
      end
    end else begin
      start_fresh(b);
    end
    if (eot && seq_need != u8d_pkg::EXP_NONE) begin
      add_replacements(1 + seq_got);
      drop_sequence();
    end
    for (int k = 0; k < run_len; k++) begin
      if (k == run_len - 1) run_buf[k].last = 1'b1;
      cp_expect_q.insert(cp_expect_q.size(), run_buf[k]);
    end
  endfunction

  always @(posedge clk) begin
    cp_word_t want;
    if (!rst_n) begin
      surr_ok = 1'b0;
      drop_sequence();
      cp_expect_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) surr_ok = cfg_wr_data;
      if (in_valid && !in_stall) decode_byte(in_byte_value, in_end_of_text);
      if (out_valid && !out_stall) begin
        if (cp_expect_q.size() == 0) begin
          $error("unexpected word: scalar %h", out_scalar);
          fail_count++;
        end else begin
          want = cp_expect_q.pop_front();
          if (out_scalar !== want.cp) begin
            $error("scalar: expected %h, got %h", want.cp, out_scalar);
            fail_count++;
          end
          if (out_is_error !== want.err) begin
            $error("is_error: expected %b, got %b", want.err, out_is_error);
            fail_count++;
          end
          if (out_run_last !== want.last) begin
            $error("run_last: expected %b, got %b", want.last, out_run_last);
            fail_count++;
          end
        end
      end
    end
    words_pending = cp_expect_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the utf8_stream_decoder bench: clock, reset, byte stimulus and the verdict.
// Depends on u8d_pkg, the decoder RTL and utf8_cp_checker.
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 8;

  logic                     clk;
  logic                     rst_n          = 1'b0;
  logic                     cfg_wr_en      = 1'b0;
  logic                     cfg_wr_data    = 1'b0;
  logic                     in_valid       = 1'b0;
  logic [7:0]               in_byte_value  = 8'h00;
  logic                     in_end_of_text = 1'b0;
  logic                     out_stall      = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic [u8d_pkg::CP_W-1:0] out_scalar;
  logic                     out_is_error;
  logic                     out_run_last;

  int         fail_count;
  int         words_pending;
  int         cycle_count = 0;
  logic       calm        = 1'b0;
  int         hold_armed  = 0;
  int         hold_done   = 0;
  int         hold_left   = 0;
  logic [7:0] text_q[$];

  utf8_stream_decoder u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_value (in_byte_value),
    .in_end_of_text(in_end_of_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scalar    (out_scalar),
    .out_is_error  (out_is_error),
    .out_run_last  (out_run_last)
  );

  utf8_cp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_value (in_byte_value),
    .in_end_of_text(in_end_of_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scalar    (out_scalar),
    .out_is_error  (out_is_error),
    .out_run_last  (out_run_last),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when armed
  always @(negedge clk) begin
    if (hold_left == 0 && hold_done != hold_armed) begin
      hold_left = HOLD_CYCLES;
      hold_done = hold_armed;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 17);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_byte_value  <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Send the queued text, flagging the last word as end of text
  task automatic send_text();
    logic [7:0] b;
    while (text_q.size() != 0) begin
      b = text_q.pop_front();
      send_byte(b, text_q.size() == 0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_surrogate_mode(input logic allow);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= allow;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic void queue_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic logic [7:0] random_lead(input int need);
    case (need)
      1: return 8'hC0 | 8'($urandom_range(0, 31));
      2: return ($urandom_range(0, 3) == 0) ? 8'hED : (8'hE0 | 8'($urandom_range(0, 15)));
      default: return ($urandom_range(0, 3) == 0) ? 8'hF4 : (8'hF0 | 8'($urandom_range(0, 7)));
    endcase
  endfunction

  // Mostly well-formed sequences with random payload; the rest is noise
  function automatic void make_sequence();
    int need;
    int conts;
    need  = 0;
    conts = 0;
    case ($urandom_range(0, 9))
      0, 1: queue_byte(8'($urandom_range(0, 127)));
      2, 3, 4, 5: begin
        need  = $urandom_range(1, 3);
        conts = need;
      end
      6: begin
        need  = $urandom_range(1, 3);
        conts = $urandom_range(0, need - 1);
      end
      7: queue_byte(8'($urandom_range(0, 255)));
      8: queue_byte(8'h80 | 8'($urandom_range(0, 63)));
      default: begin
        need  = 3;
        conts = 3;
      end
    endcase
    if (need != 0) begin
      queue_byte(random_lead(need));
      repeat (conts) queue_byte(8'h80 | 8'($urandom_range(0, 63)));
      // truncated: break it with a fresh byte
      if (conts < need)
        queue_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                        : random_lead($urandom_range(1, 3)));
    end
  endfunction

  task automatic run_random(input int count, input int calm_for, input int hold_at);
    int sent;
    sent = 0;
    while (sent < count) begin
      make_sequence();
      while (text_q.size() != 0) begin
        calm <= (sent < calm_for);
        if (sent == hold_at) hold_armed <= hold_armed + 1;
        send_byte(text_q.pop_front(), $urandom_range(0, 19) == 0);
        sent++;
      end
    end
    // close the text so nothing stays pending across a config write
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    calm <= 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    write_surrogate_mode(1'b0);
    // ASCII limits, bad lead, broken 3-byte, max scalar, above range, overlong,
    // surrogate, encoded FFFD, and a partial 4-byte flushed by end of text
    text_q = '{8'h00, 8'h7F, 8'hFF, 8'hE2, 8'h41, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
               8'hF4, 8'h90, 8'h80, 8'h80, 8'hE0, 8'h80, 8'h80, 8'hED, 8'hA0,
               8'h80, 8'hEF, 8'hBF, 8'hBD, 8'hF0, 8'h9F, 8'h98};
    send_text();
    drain();

    write_surrogate_mode(1'b1);
    text_q = '{8'hED, 8'hA0, 8'h80};
    send_text();
    run_random(90, 0, 20);
    drain();

    write_surrogate_mode(1'b0);
    run_random(100, 60, -1);
    drain();

    write_surrogate_mode(1'b1);
    run_random(90, 0, -1);
    drain();

    if (fail_count == 0 && words_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== utf8_stream_decoder.f =====
src/u8d_pkg.sv
src/u8d_decode.sv
src/u8d_emit.sv
src/utf8_stream_decoder.sv
tb/utf8_cp_checker.sv
tb/testbench.sv
